### rtl/tlk_pkg.sv
// ----------------------------------------------------------------------------
// tlk_pkg
// Shared types and codes for the level-order trie transliteration lookup.
// ----------------------------------------------------------------------------
package tlk_pkg;

	// Input item kinds
	localparam logic [2:0] KIND_CHAR   = 3'd0;
	localparam logic [2:0] KIND_COUNT  = 3'd1;
	localparam logic [2:0] KIND_MAP    = 3'd2;
	localparam logic [2:0] KIND_OCHAR  = 3'd3;
	localparam logic [2:0] KIND_OPAR   = 3'd4;
	localparam logic [2:0] KIND_LOOKUP = 3'd5;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_NO_MAP    = 2'd2;
	localparam logic [1:0] ST_TOO_LONG  = 2'd3;

	localparam logic [15:0] NO_MAP = 16'hFFFF;

	// Classified operation handed from front to back
	typedef enum logic [2:0] {
		OP_WR_CHAR,
		OP_WR_COUNT,
		OP_WR_MAP,
		OP_WR_OCHAR,
		OP_WR_OPAR,
		OP_LOOKUP
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [12:0] addr;
		logic [15:0] value;
		logic        word_end;
	} item_t;

endpackage

### rtl/tlk_front.sv
// ----------------------------------------------------------------------------
// tlk_front
// Accepts items, classifies the kind, drops unused kinds and queues the rest
// in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module tlk_front
	import tlk_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [2:0]  kind,
	input  logic [12:0] addr,
	input  logic [15:0] value,
	input  logic        word_end,
	output logic        busy,
	output logic        q_valid,
	output item_t       q_item,
	input  logic        q_pop
);

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       keep;
	op_t        op;

	// Kind decode
	always_comb begin
		keep = 1'b1;
		op   = OP_LOOKUP;
		case (kind)
			KIND_CHAR:   op = OP_WR_CHAR;
			KIND_COUNT:  op = OP_WR_COUNT;
			KIND_MAP:    op = OP_WR_MAP;
			KIND_OCHAR:  op = OP_WR_OCHAR;
			KIND_OPAR:   op = OP_WR_OPAR;
			KIND_LOOKUP: op = OP_LOOKUP;
			default:     keep = 1'b0;
		endcase
	end

	assign busy    = (cnt_q == 2'd2);
	assign push    = start && !busy && keep;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = slot_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{op: op, addr: addr, value: value, word_end: word_end};
		end
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

### rtl/tlk_engine.sv
// ----------------------------------------------------------------------------
// tlk_engine
// Back end: table writes, sibling search, child-count sums, parent-chain
// walk into the unit buffer and root-first emission of results.
// ----------------------------------------------------------------------------
module tlk_engine
	import tlk_pkg::*;
#(
	parameter int NODE_COUNT     = 4096,
	parameter int OUT_NODE_COUNT = 4096,
	parameter int MAX_OUT_LEN    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        q_pop,
	output logic        strobe,
	output logic [15:0] code_unit,
	output logic [1:0]  status,
	output logic        final_res
);

	localparam int NW  = $clog2(NODE_COUNT);
	localparam int CW  = $clog2(NODE_COUNT + 1);
	localparam int OW  = $clog2(OUT_NODE_COUNT);
	localparam int BW  = $clog2(MAX_OUT_LEN);
	localparam int NCW = $clog2(MAX_OUT_LEN + 1);
	localparam logic [16:0] NODE_LIM = 17'(NODE_COUNT);
	localparam logic [16:0] OUT_LIM  = 17'(OUT_NODE_COUNT);
	localparam logic [NCW-1:0] MAX_N = NCW'(MAX_OUT_LEN);

	typedef enum logic [3:0] {
		S_IDLE, S_ROOT, S_ROOT_D, S_SRCH, S_SRCH_D, S_SUM, S_SUM_D,
		S_NXT, S_NXT_D, S_MAP, S_MAP_D, S_WALK, S_WALK_D, S_ERD, S_EOUT
	} state_t;

	state_t state_q;

	// Memories
	logic [7:0]  nc_mem  [NODE_COUNT];
	logic [7:0]  cc_mem  [NODE_COUNT + 1];
	logic [15:0] map_mem [NODE_COUNT];
	logic [15:0] oc_mem  [OUT_NODE_COUNT];
	logic [12:0] op_mem  [OUT_NODE_COUNT];
	logic [15:0] buf_mem [MAX_OUT_LEN];

	logic [7:0]  nc_rd_q, cc_rd_q;
	logic [15:0] map_rd_q, oc_rd_q, buf_rd_q;
	logic [12:0] op_rd_q;

	// Word state
	logic [15:0] rs_q, re_q, nsn_q, matched_q, j_q, k_q, u_q;
	logic        miss_q, active_q;
	logic [15:0] ch_q;
	logic        last_q;
	logic [NCW-1:0] n_q;
	logic [BW-1:0]  e_q;

	// Write decode
	logic        pop;
	logic [16:0] wa;
	logic        we_nc, we_cc, we_map, we_oc, we_op;
	logic [15:0] cc_ra;
	logic        buf_we;

	assign pop   = (state_q == S_IDLE) && q_valid;
	assign q_pop = pop;
	assign wa    = {4'd0, q_item.addr};
	assign we_nc  = pop && q_item.op == OP_WR_CHAR  && wa < NODE_LIM;
	assign we_cc  = pop && q_item.op == OP_WR_COUNT && wa <= NODE_LIM;
	assign we_map = pop && q_item.op == OP_WR_MAP   && wa < NODE_LIM;
	assign we_oc  = pop && q_item.op == OP_WR_OCHAR && wa < OUT_LIM;
	assign we_op  = pop && q_item.op == OP_WR_OPAR  && wa < OUT_LIM;

	// Child-count read address
	always_comb begin
		case (state_q)
			S_ROOT:  cc_ra = 16'd0;
			S_NXT:   cc_ra = j_q + 16'd1;
			default: cc_ra = k_q;
		endcase
	end

	// Source-trie tables
	always_ff @(posedge clk) begin
		if (we_nc) nc_mem[wa[NW-1:0]] <= q_item.value[7:0];
		if (we_cc) cc_mem[wa[CW-1:0]] <= q_item.value[7:0];
		if (we_map) map_mem[wa[NW-1:0]] <= q_item.value;
		nc_rd_q  <= nc_mem[j_q[NW-1:0]];
		cc_rd_q  <= cc_mem[cc_ra[CW-1:0]];
		map_rd_q <= map_mem[matched_q[NW-1:0]];
	end

	// Output-trie tables
	always_ff @(posedge clk) begin
		if (we_oc) oc_mem[wa[OW-1:0]] <= q_item.value;
		if (we_op) op_mem[wa[OW-1:0]] <= q_item.value[12:0];
		oc_rd_q <= oc_mem[u_q[OW-1:0]];
		op_rd_q <= op_mem[u_q[OW-1:0]];
	end

	// Walk checks
	logic        u_in;
	logic [15:0] ch_u;
	logic [12:0] par_u;
	assign u_in   = {1'b0, u_q} < OUT_LIM;
	assign ch_u   = u_in ? oc_rd_q : 16'd0;
	assign par_u  = u_in ? op_rd_q : 13'd0;
	assign buf_we = (state_q == S_WALK_D) && (n_q != MAX_N);

	// Unit buffer
	always_ff @(posedge clk) begin
		if (buf_we) buf_mem[n_q[BW-1:0]] <= ch_u;
		buf_rd_q <= buf_mem[e_q];
	end

	// Sequencer
	logic in_range;
	logic hit;
	assign in_range = (j_q < re_q) && ({1'b0, j_q} < NODE_LIM);
	assign hit      = (ch_q[15:8] == 8'd0) && (ch_q[7:0] == nc_rd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rs_q      <= 16'd0;
			re_q      <= 16'd0;
			nsn_q     <= 16'd1;
			matched_q <= 16'd0;
			miss_q    <= 1'b0;
			active_q  <= 1'b0;
			j_q       <= 16'd0;
			k_q       <= 16'd0;
			u_q       <= 16'd0;
			ch_q      <= 16'd0;
			last_q    <= 1'b0;
			n_q       <= '0;
			e_q       <= '0;
			strobe    <= 1'b0;
			code_unit <= 16'd0;
			status    <= ST_OK;
			final_res <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (pop && q_item.op == OP_LOOKUP) begin
						ch_q   <= q_item.value;
						last_q <= q_item.word_end;
						if (!active_q) begin
							state_q <= S_ROOT;
						end else if (miss_q) begin
							if (q_item.word_end) begin
								strobe    <= 1'b1;
								code_unit <= 16'd0;
								status    <= ST_NOT_FOUND;
								final_res <= 1'b1;
								rs_q      <= 16'd0;
								re_q      <= 16'd0;
								nsn_q     <= 16'd1;
								matched_q <= 16'd0;
								miss_q    <= 1'b0;
								active_q  <= 1'b0;
							end
						end else begin
							j_q     <= rs_q;
							state_q <= S_SRCH;
						end
					end
				end
				S_ROOT: state_q <= S_ROOT_D;
				S_ROOT_D: begin
					re_q      <= {8'd0, cc_rd_q};
					rs_q      <= 16'd0;
					nsn_q     <= 16'd1;
					matched_q <= 16'd0;
					miss_q    <= 1'b0;
					active_q  <= 1'b1;
					j_q       <= 16'd0;
					state_q   <= S_SRCH;
				end
				// Linear search of the sibling range
				S_SRCH: begin
					if (in_range) begin
						state_q <= S_SRCH_D;
					end else if (last_q) begin
						strobe    <= 1'b1;
						code_unit <= 16'd0;
						status    <= ST_NOT_FOUND;
						final_res <= 1'b1;
						rs_q      <= 16'd0;
						re_q      <= 16'd0;
						nsn_q     <= 16'd1;
						matched_q <= 16'd0;
						miss_q    <= 1'b0;
						active_q  <= 1'b0;
						state_q   <= S_IDLE;
					end else begin
						miss_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_SRCH_D: begin
					if (hit) begin
						k_q     <= nsn_q;
						state_q <= S_SUM;
					end else begin
						j_q     <= j_q + 16'd1;
						state_q <= S_SRCH;
					end
				end
				// Prefix sum of child counts up to the match
				S_SUM: state_q <= (k_q <= j_q) ? S_SUM_D : S_NXT;
				S_SUM_D: begin
					re_q    <= re_q + {8'd0, cc_rd_q};
					k_q     <= k_q + 16'd1;
					state_q <= S_SUM;
				end
				S_NXT: state_q <= S_NXT_D;
				S_NXT_D: begin
					nsn_q     <= j_q + 16'd2;
					rs_q      <= re_q;
					re_q      <= re_q + {8'd0, cc_rd_q};
					matched_q <= j_q;
					state_q   <= last_q ? S_MAP : S_IDLE;
				end
				S_MAP: state_q <= S_MAP_D;
				S_MAP_D: begin
					if (map_rd_q == NO_MAP || map_rd_q == 16'd0) begin
						strobe    <= 1'b1;
						code_unit <= 16'd0;
						status    <= ST_NO_MAP;
						final_res <= 1'b1;
						rs_q      <= 16'd0;
						re_q      <= 16'd0;
						nsn_q     <= 16'd1;
						matched_q <= 16'd0;
						miss_q    <= 1'b0;
						active_q  <= 1'b0;
						state_q   <= S_IDLE;
					end else begin
						u_q     <= map_rd_q;
						n_q     <= '0;
						state_q <= S_WALK;
					end
				end
				// Parent chain walk, one node per pass through S_WALK and S_WALK_D
				S_WALK: state_q <= S_WALK_D;
				S_WALK_D: begin
					if (n_q == MAX_N) begin
						strobe    <= 1'b1;
						code_unit <= 16'd0;
						status    <= ST_TOO_LONG;
						final_res <= 1'b1;
						rs_q      <= 16'd0;
						re_q      <= 16'd0;
						nsn_q     <= 16'd1;
						matched_q <= 16'd0;
						miss_q    <= 1'b0;
						active_q  <= 1'b0;
						state_q   <= S_IDLE;
					end else begin
						n_q <= n_q + NCW'(1);
						if (par_u == 13'd0) begin
							e_q     <= n_q[BW-1:0];
							state_q <= S_ERD;
						end else begin
							u_q     <= {3'd0, par_u - 13'd1};
							state_q <= S_WALK;
						end
					end
				end
				// Root-first emission
				S_ERD: state_q <= S_EOUT;
				S_EOUT: begin
					strobe    <= 1'b1;
					code_unit <= buf_rd_q;
					status    <= ST_OK;
					final_res <= (e_q == '0);
					if (e_q == '0) begin
						rs_q      <= 16'd0;
						re_q      <= 16'd0;
						nsn_q     <= 16'd1;
						matched_q <= 16'd0;
						miss_q    <= 1'b0;
						active_q  <= 1'b0;
						state_q   <= S_IDLE;
					end else begin
						e_q     <= e_q - BW'(1);
						state_q <= S_ERD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/level_order_trie_translit_lookup_top.sv
// ----------------------------------------------------------------------------
// level_order_trie_translit_lookup_top
// Level-order trie lookup with output-trie walk, UTF-16 units out.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; a two-entry queue
// sits in front of the engine, so busy rises only when both entries wait.
// Table writes are made in the engine as the item leaves the queue. A lookup
// character searches the siblings and then sums child counts, one table read
// at a time through the one registered read port of each table. On the last
// character the parent chain is walked one output node at a time, then the
// units come out root-first from the unit buffer. Results appear for one cycle
// on strobe and cannot be held off by the receiver.
module level_order_trie_translit_lookup_top
	import tlk_pkg::*;
#(
	parameter int NODE_COUNT     = 4096,
	parameter int OUT_NODE_COUNT = 4096,
	parameter int MAX_OUT_LEN    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [12:0] addr,
	input  logic [15:0] value,
	input  logic        word_end,
	output logic        strobe,
	output logic [15:0] code_unit,
	output logic [1:0]  status,
	output logic        final_res
);

	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	tlk_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .kind(kind), .addr(addr),
		.value(value), .word_end(word_end), .busy(busy), .q_valid(q_valid),
		.q_item(q_item), .q_pop(q_pop)
	);

	tlk_engine #(
		.NODE_COUNT(NODE_COUNT), .OUT_NODE_COUNT(OUT_NODE_COUNT),
		.MAX_OUT_LEN(MAX_OUT_LEN)
	) u_engine (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_item(q_item),
		.q_pop(q_pop), .strobe(strobe), .code_unit(code_unit),
		.status(status), .final_res(final_res)
	);

endmodule

### rtl/tlk_checker.sv
// ----------------------------------------------------------------------------
// tlk_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module tlk_checker
	import tlk_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        strobe,
	input logic [15:0] code_unit,
	input logic [1:0]  status,
	input logic        final_res
);

	// Error results close the word
	a_err_final: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status != ST_OK |-> final_res)
		else $error("error result without final mark");

	// Error results carry no unit
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status != ST_OK |-> code_unit == 16'd0)
		else $error("error result with nonzero unit");

	// Units of one word are spaced by the buffer read
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !final_res |=> !strobe)
		else $error("back-to-back units within a word");

	// A non-final result is always an ok unit
	a_mid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !final_res |-> status == ST_OK)
		else $error("non-final result with error status");

endmodule

bind level_order_trie_translit_lookup_top tlk_checker u_checker (
	.clk(clk), .arst_n(arst_n), .strobe(strobe), .code_unit(code_unit),
	.status(status), .final_res(final_res)
);

### verif/tlk_lookup_checker.sv
// ----------------------------------------------------------------------------
// tlk_lookup_checker
// Watches the item and result channels of the trie lookup, predicts the
// UTF-16 units of each word and compares them with what the block gives.
// ----------------------------------------------------------------------------
module tlk_lookup_checker
	import tlk_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  kind,
	input  logic [12:0] addr,
	input  logic [15:0] value,
	input  logic        word_end,
	input  logic        strobe,
	input  logic [15:0] code_unit,
	input  logic [1:0]  status,
	input  logic        final_res,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES = 4096;
	localparam int ONODES = 4096;
	localparam int OUT_MAX = 32;

	typedef struct {
		logic [15:0] unit;
		logic [1:0]  st;
		logic        fin;
	} unit_res_t;

	unit_res_t units_due[$];

	// Shadow tables
	bit [7:0]  node_chr[NODES];
	bit [7:0]  kid_cnt[NODES + 1];
	bit [15:0] map_idx[NODES];
	bit [15:0] out_chr[ONODES];
	bit [12:0] out_par[ONODES];

	// Word walk state
	bit [15:0] rng_lo;
	bit [15:0] rng_hi;
	bit [15:0] sum_from;
	bit [15:0] hit_node;
	bit        missed;
	bit        in_word;
	bit [15:0] chain[OUT_MAX];

	task automatic report(input string what, input int got, input int want);
		$display("mismatch @%0t: %s got %0h want %0h", $realtime, what, got, want);
		errors++;
	endtask

	task automatic word_reset();
		rng_lo = 0;
		rng_hi = 0;
		sum_from = 1;
		hit_node = 0;
		missed = 0;
		in_word = 0;
	endtask

	function automatic bit [7:0] cnt_at(int k);
		return (k <= NODES) ? kid_cnt[k] : 8'd0;
	endfunction

	task automatic push_unit(input bit [15:0] u, input bit [1:0] st, input bit fin);
		unit_res_t r;
		r.unit = u;
		r.st = st;
		r.fin = fin;
		units_due.insert(units_due.size(), r);
	endtask

	// Sibling search, then prefix sums give the child range of the match
	task automatic step_char(input bit [15:0] ch);
		int j;
		bit hit;
		hit = 0;
		for (j = rng_lo; j < rng_hi && j < NODES; j++) begin
			if (node_chr[j] == ch) begin
				hit = 1;
				break;
			end
		end
		if (!hit) begin
			missed = 1;
			return;
		end
		for (int k = sum_from; k <= j; k++)
			rng_hi = rng_hi + cnt_at(k);
		sum_from = j + 2;
		rng_lo = rng_hi;
		rng_hi = rng_hi + cnt_at(j + 1);
		hit_node = j;
	endtask

	// Walk the output parent chain, emit root-first
	task automatic end_word();
		int u;
		int p;
		int n;
		n = 0;
		if (missed) begin
			push_unit(0, ST_NOT_FOUND, 1);
			return;
		end
		u = (hit_node < NODES) ? map_idx[hit_node] : 0;
		if (u == NO_MAP || u == 0) begin
			push_unit(0, ST_NO_MAP, 1);
			return;
		end
		chain[n++] = (u < ONODES) ? out_chr[u] : 0;
		forever begin
			p = (u < ONODES) ? out_par[u] : 0;
			if (p == 0)
				break;
			u = p - 1;
			if (n >= OUT_MAX) begin
				push_unit(0, ST_TOO_LONG, 1);
				return;
			end
			chain[n++] = (u < ONODES) ? out_chr[u] : 0;
		end
		for (int i = 0; i < n; i++)
			push_unit(chain[n - 1 - i], ST_OK, i + 1 == n);
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_reset();
		end else begin
			// Result side
			if (strobe) begin
				if (units_due.size() == 0) begin
					report("unexpected result unit", code_unit, 0);
				end else begin
					unit_res_t w;
					w = units_due.pop_front();
					if (code_unit !== w.unit)
						report("code_unit", code_unit, w.unit);
					if (status !== w.st)
						report("status", status, w.st);
					if (final_res !== w.fin)
						report("final_res", final_res, w.fin);
				end
			end
			// Item side
			if (start && !busy) begin
				case (kind)
					KIND_CHAR:   if (addr < NODES) node_chr[addr] = value[7:0];
					KIND_COUNT:  if (addr <= NODES) kid_cnt[addr] = value[7:0];
					KIND_MAP:    if (addr < NODES) map_idx[addr] = value;
					KIND_OCHAR:  if (addr < ONODES) out_chr[addr] = value;
					KIND_OPAR:   if (addr < ONODES) out_par[addr] = value[12:0];
					KIND_LOOKUP: begin
						if (!in_word) begin
							word_reset();
							rng_hi = kid_cnt[0];
							in_word = 1;
						end
						if (!missed)
							step_char(value);
						if (word_end) begin
							end_word();
							word_reset();
						end
					end
					default: ;
				endcase
			end
			pending = units_due.size();
		end
	end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Loads a small level-order trie and output trie into the lookup block, then
// feeds words (mostly real paths, some broken) with random start gaps.
// ----------------------------------------------------------------------------
module tb
	import tlk_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] KIND_SPARE_LO = 3'd6;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TRIE_MAX = 32;
	localparam int OTRIE = 48;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  kind;
	logic [12:0] addr;
	logic [15:0] value;
	logic        word_end;
	logic        strobe;
	logic [15:0] code_unit;
	logic [1:0]  status;
	logic        final_res;
	int          errors;
	int          pending;
	int          cycles = 0;
	bit          calm;

	// Layout being loaded
	bit [7:0]  trie_chr[TRIE_MAX];
	bit [7:0]  trie_cnt[TRIE_MAX + 1];
	bit [15:0] trie_map[TRIE_MAX];
	bit [15:0] o_chr[OTRIE];
	bit [12:0] o_par[OTRIE];
	int        n_nodes;
	int        n_out;

	level_order_trie_translit_lookup_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .addr(addr), .value(value), .word_end(word_end),
		.strobe(strobe), .code_unit(code_unit), .status(status),
		.final_res(final_res)
	);

	tlk_lookup_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .addr(addr), .value(value), .word_end(word_end),
		.strobe(strobe), .code_unit(code_unit), .status(status),
		.final_res(final_res), .errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// One item: optional idle gap, then hold start until taken
	task automatic send(input logic [2:0] k, input int a, input int v, input bit last);
		int gap;
		bit free;
		gap = 0;
		if (!calm && $urandom_range(0, 1))
			gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		addr <= 13'(a);
		value <= 16'(v);
		word_end <= last;
		do begin
			@(negedge clk);
			free = !busy;
			@(posedge clk);
		end while (!free);
	endtask

	// Let every expected unit arrive, then let the engine drain
	task automatic settle();
		start <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (300) @(posedge clk);
	endtask

	// Write the whole current layout; garbage in bits the tables drop
	task automatic load_layout();
		for (int i = 0; i < n_nodes; i++)
			send(KIND_CHAR, i, {8'($urandom), trie_chr[i]}, $urandom_range(0, 1));
		for (int i = 0; i <= n_nodes; i++)
			send(KIND_COUNT, i, {8'($urandom), trie_cnt[i]}, 0);
		for (int i = 0; i < n_nodes; i++)
			send(KIND_MAP, i, trie_map[i], 0);
		for (int i = 0; i < n_out; i++)
			send(KIND_OCHAR, i, o_chr[i], 0);
		for (int i = 0; i < n_out; i++)
			send(KIND_OPAR, i, {3'($urandom), o_par[i]}, 0);
	endtask

	function automatic int first_kid(int k);
		int s;
		s = 0;
		for (int t = 0; t < k; t++)
			s += trie_cnt[t];
		return s;
	endfunction

	task automatic send_word(input int n, input int w[8]);
		for (int i = 0; i < n; i++)
			send(KIND_LOOKUP, $urandom, w[i], i == n - 1);
	endtask

	// Random word along a trie path, sometimes broken
	task automatic random_word();
		int w[8];
		int n;
		int len;
		int lo;
		int cnt;
		int j;
		n = 0;
		lo = 0;
		cnt = trie_cnt[0];
		len = $urandom_range(1, 5);
		while (n < len && cnt > 0) begin
			j = lo + $urandom_range(0, cnt - 1);
			w[n++] = trie_chr[j];
			lo = first_kid(j + 1);
			cnt = trie_cnt[j + 1];
		end
		if ($urandom_range(0, 6) == 0)
			w[$urandom_range(0, n - 1)] = $urandom_range(0, 1) ? $urandom_range(0, 255)
				: $urandom_range(0, 65535);
		send_word(n, w);
	endtask

	initial begin
		int w[8];
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_CHAR;
		addr = '0;
		value = '0;
		word_end = 1'b0;
		calm = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed trie: root 'a' 'b' 0xFF, 'a' has child 'c'; straight output chain
		n_nodes = 4;
		trie_chr[0] = 8'h61; trie_chr[1] = 8'h62; trie_chr[2] = 8'hFF; trie_chr[3] = 8'h63;
		trie_cnt[0] = 3; trie_cnt[1] = 1; trie_cnt[2] = 0; trie_cnt[3] = 0; trie_cnt[4] = 0;
		trie_map[0] = 31;       // 32 units: longest that fits
		trie_map[1] = 0;        // index zero, no mapping
		trie_map[2] = NO_MAP;
		trie_map[3] = 32;       // one unit too many
		n_out = 40;
		for (int i = 0; i < n_out; i++) begin
			o_chr[i] = $urandom;
			o_par[i] = i;
		end
		o_chr[31] = 16'hFFFF;
		o_chr[0] = 16'h0000;
		load_layout();
		// Ignored writes, unused kinds and a write to the top child-count entry
		send(KIND_CHAR, 4096, 16'hFFFF, 1);
		send(KIND_MAP, 8191, 16'hFFFF, 0);
		send(KIND_OPAR, 4097, 16'h0001, 0);
		send(KIND_SPARE_LO, 0, 16'hFFFF, 1);
		send(KIND_SPARE_HI, 8191, 16'h0000, 0);
		send(KIND_COUNT, 4096, 16'h00AB, 0);
		w[0] = 16'h61; send_word(1, w);                       // ok, 32 units
		w[0] = 16'h62; send_word(1, w);                       // no mapping (0)
		w[0] = 16'hFF; send_word(1, w);                       // no mapping (65535)
		w[0] = 16'h61; w[1] = 16'h63; send_word(2, w);        // too long
		w[0] = 16'h78; send_word(1, w);                       // miss at root
		w[0] = 16'h61; w[1] = 16'h78; w[2] = 16'h63; send_word(3, w);  // miss mid-word
		w[0] = 16'h161; send_word(1, w);                      // value beyond 8 bits
		w[0] = 16'hFFFF; w[1] = 16'h61; send_word(2, w);      // miss, then skipped
		w[0] = 16'h63; send_word(1, w);                       // child char at root: miss
		// Cyclic output chain
		settle();
		send(KIND_OPAR, 5, 16'd6, 0);
		w[0] = 16'h61; w[1] = 16'h63; send_word(2, w);
		settle();

		// Random words on the loaded trie; one phase runs without gaps
		for (int ph = 0; ph < 2; ph++) begin
			calm = (ph == 1);
			repeat (8) random_word();
			settle();
		end

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
